[hw/rtl/rmf_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmf_pkg: shared types for the running median filter
// Command codes, sequencer state codes and the control bundle sent to every cell.
// ---------------------------------------------------------------------------
package rmf_pkg;

  // Command codes
  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_RANK = 5'b00100,
    S_PICK = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  // Control bundle broadcast to the cell row
  typedef struct packed {
    logic load;   // copy own sample into the travel slot, clear rank
    logic shift;  // compare travel against own, pass travel on
    logic pick;   // pass the selected sample down the row
  } cell_ctl_t;

endpackage

[hw/rtl/rmf_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmf_cell: one window slot of the running median filter
// Holds one sample, ranks it against samples that circulate around the
// ring, then forwards either its own sample or its neighbor's pick.
// ---------------------------------------------------------------------------
module rmf_cell #(
  parameter int WINDOW = 10,
  parameter int IDX    = 0,
  localparam int IW    = $clog2(WINDOW),
  localparam int FW    = $clog2(WINDOW + 1)
) (
  input  logic                clk,
  input  rmf_pkg::cell_ctl_t  ctl,
  input  logic                wr_en,
  input  logic signed [7:0]   wr_data,
  input  logic                slot_vld,
  input  logic [FW-1:0]       target,
  input  logic signed [7:0]   trv_val_in,
  input  logic [IW-1:0]       trv_idx_in,
  input  logic                trv_vld_in,
  input  logic signed [7:0]   pick_in,
  output logic signed [7:0]   trv_val,
  output logic [IW-1:0]       trv_idx,
  output logic                trv_vld,
  output logic signed [7:0]   pick
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic signed [7:0] own;
  logic              own_vld;
  logic [FW-1:0]     rank;
  logic              below;

  // Traveler sorts before own sample; ties broken by slot index
  assign below = own_vld && trv_vld &&
                 ((trv_val < own) || ((trv_val == own) && (trv_idx < MY_IDX)));

  // Sample storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      own <= wr_data;
    end
  end

  // Ranking ring
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      trv_val <= own;
      trv_idx <= MY_IDX;
      trv_vld <= slot_vld;
      own_vld <= slot_vld;
      rank    <= '0;
    end else if (ctl.shift) begin
      trv_val <= trv_val_in;
      trv_idx <= trv_idx_in;
      trv_vld <= trv_vld_in;
      if (below) begin
        rank <= rank + FW'(1);
      end
    end
  end

  // Selection chain: the one cell whose rank hits the target injects
  always_ff @(posedge clk) begin
    if (ctl.pick) begin
      pick <= (own_vld && (rank == target)) ? own : pick_in;
    end
  end

endmodule

[hw/rtl/running_median_rssi_filter.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// running_median_rssi_filter: upper median over the last WINDOW samples
// A row of WINDOW cells holds the ring. Each push ranks all filled slots
// by circulating copies around the row, then shifts the median out.
// ---------------------------------------------------------------------------
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  input   | in_valid, in_stall, command,     | in (stall out)
//          | sample                           |
//  output  | out_valid, out_stall, median,    | out (stall in)
//          | sample_count                     |
//
// A push passes through one load step, WINDOW ranking shifts around the cell
// ring, WINDOW shifts down the selection chain and one step into the output
// register. A clear goes straight to the output register. No new beat is
// taken until the last one has left the sequencer for the output register.
// in_stall is high while the sequencer is busy, and the last step waits while
// a stalled result still holds the output register; the next beat is accepted
// while a result waits in the output register.
// rst is synchronous; it empties the window and drops out_valid.
//
module running_median_rssi_filter #(
  parameter int WINDOW = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              command,
  input  logic signed [7:0] sample,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] median,
  output logic [3:0]        sample_count
);

  localparam int IW = $clog2(WINDOW);
  localparam int FW = $clog2(WINDOW + 1);
  localparam logic [IW-1:0] LAST_POS = IW'(WINDOW - 1);
  localparam logic [FW-1:0] FULL     = FW'(WINDOW);

  rmf_pkg::state_t    state, state_next;
  rmf_pkg::cell_ctl_t ctl;
  logic [IW-1:0]      write_position;
  logic [FW-1:0]      fill_count;
  logic [IW-1:0]      step;
  logic               is_clear;
  logic               in_acc;
  logic               out_free;
  logic               step_last;
  logic [FW+3:0]      fill_ext;

  logic signed [7:0] trv_val [WINDOW];
  logic [IW-1:0]     trv_idx [WINDOW];
  logic              trv_vld [WINDOW];
  logic signed [7:0] pick    [WINDOW];

  assign in_stall  = (state != rmf_pkg::S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign step_last = (step == LAST_POS);
  assign fill_ext  = {4'b0000, fill_count};

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      rmf_pkg::S_IDLE: begin
        if (in_acc) begin
          state_next = (command == rmf_pkg::CMD_CLEAR) ? rmf_pkg::S_DONE
                                                        : rmf_pkg::S_LOAD;
        end
      end
      rmf_pkg::S_LOAD: state_next = rmf_pkg::S_RANK;
      rmf_pkg::S_RANK: if (step_last) state_next = rmf_pkg::S_PICK;
      rmf_pkg::S_PICK: if (step_last) state_next = rmf_pkg::S_DONE;
      rmf_pkg::S_DONE: if (out_free) state_next = rmf_pkg::S_IDLE;
      default:         state_next = rmf_pkg::S_IDLE;
    endcase
  end

  assign ctl.load  = (state == rmf_pkg::S_LOAD);
  assign ctl.shift = (state == rmf_pkg::S_RANK);
  assign ctl.pick  = (state == rmf_pkg::S_PICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Step counter for the ranking and selection passes
  always_ff @(posedge clk) begin
    if (rst || ctl.load || step_last) begin
      step <= '0;
    end else if (ctl.shift || ctl.pick) begin
      step <= step + IW'(1);
    end
  end

  // Ring pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
      fill_count     <= '0;
    end else if (in_acc) begin
      if (command == rmf_pkg::CMD_CLEAR) begin
        write_position <= '0;
        fill_count     <= '0;
      end else begin
        write_position <= (write_position == LAST_POS) ? '0 : write_position + IW'(1);
        if (fill_count != FULL) begin
          fill_count <= fill_count + FW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      is_clear <= (command == rmf_pkg::CMD_CLEAR);
    end
  end

  // Cell row
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    localparam int PREV = (i == 0) ? WINDOW - 1 : i - 1;
    logic signed [7:0] pick_src;
    logic              slot_vld;
    logic              wr_en;

    assign pick_src = (i == 0) ? 8'sd0 : pick[PREV];
    assign slot_vld = (FW'(i) < fill_count);
    assign wr_en    = in_acc && (command == rmf_pkg::CMD_PUSH) &&
                      (write_position == IW'(i));

    rmf_cell #(
      .WINDOW (WINDOW),
      .IDX    (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .wr_en      (wr_en),
      .wr_data    (sample),
      .slot_vld   (slot_vld),
      .target     (fill_count >> 1),
      .trv_val_in (trv_val[PREV]),
      .trv_idx_in (trv_idx[PREV]),
      .trv_vld_in (trv_vld[PREV]),
      .pick_in    (pick_src),
      .trv_val    (trv_val[i]),
      .trv_idx    (trv_idx[i]),
      .trv_vld    (trv_vld[i]),
      .pick       (pick[i])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == rmf_pkg::S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == rmf_pkg::S_DONE) && out_free) begin
      median       <= is_clear ? 8'sd0 : pick[WINDOW-1];
      sample_count <= (fill_ext > (FW+4)'(15)) ? 4'd15 : fill_ext[3:0];
    end
  end

endmodule

[hw/rtl/rmf_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmf_checker: port-level checks for the running median filter
// Watches the top-level ports and is bound to every instance.
// ---------------------------------------------------------------------------
module rmf_checker #(
  parameter int WINDOW = 10
) (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [7:0] median,
  input logic [3:0]        sample_count
);

  localparam int SAT = (WINDOW > 15) ? 15 : WINDOW;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(median) && $stable(sample_count))
    else $error("result beat changed while stalled");

  // The block is busy in the cycle after it takes a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted back to back");

  // An empty window reports median zero
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (sample_count == 4'd0) |-> (median == 8'sd0))
    else $error("empty window with nonzero median");

  // Count never exceeds the window
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sample_count <= 4'(SAT)))
    else $error("sample count beyond window");

endmodule

bind running_median_rssi_filter rmf_checker #(.WINDOW(WINDOW)) u_rmf_checker (.*);
